FILE: rtl/rnn_pkg.sv
package rnn_pkg;

   // Sizes of the stores and the fixed-point format.
   localparam int MAX_IN    = 32;
   localparam int MAX_HID   = 32;
   localparam int MAX_OUT   = 16;
   localparam int FRAC_BITS = 12;
   localparam int IN_W      = $clog2(MAX_IN);
   localparam int HID_W     = $clog2(MAX_HID);
   localparam int OUT_W     = $clog2(MAX_OUT);
   localparam int ACC_W     = 40;
   localparam int LUT_DEPTH = 256;

   // Activation codes.
   typedef enum logic [1:0] {
      ACT_LINEAR  = 2'd0,
      ACT_SIGMOID = 2'd1,
      ACT_TANH    = 2'd2,
      ACT_RELU    = 2'd3
   } act_type;

   // Target stores of a parameter write.
   typedef enum logic [2:0] {
      SEL_WX = 3'd0,
      SEL_WH = 3'd1,
      SEL_WY = 3'd2,
      SEL_BH = 3'd3,
      SEL_BY = 3'd4,
      SEL_H0 = 3'd5
   } sel_type;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      REG_ACT_HIDDEN = 3'd0,
      REG_ACT_OUTPUT = 3'd1,
      REG_IN_LEN     = 3'd2,
      REG_HID_LEN    = 3'd3,
      REG_OUT_LEN    = 3'd4
   } reg_idx_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HID_MAC,
      ST_HID_DRAIN,
      ST_OUT_WAIT,
      ST_OUT_MAC,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             req_fire;
      logic             mac_en;
      logic             out_phase;
      logic             src_x;
      logic [HID_W-1:0] row;
      logic [HID_W-1:0] col;
      logic             first;
      logic             last;
      logic             row_last;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic busy;
      logic rsp_full;
   } dp_stat_type;

   typedef logic signed [15:0] lut_type [LUT_DEPTH];

   // Unsigned restoring division, used only while the constant tables are built.
   function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Builds the sigmoid table (tanh_sel low) or the tanh table (tanh_sel high).
   function automatic lut_type build_lut(input logic tanh_sel);
      lut_type     res;
      logic [63:0] q30;
      logic [63:0] t;
      logic [63:0] term;
      logic [63:0] e1;
      logic [63:0] ek [LUT_DEPTH+1];
      logic [63:0] den;
      logic [63:0] val;
      int          s;
      int          a;
      q30  = 64'd1 << 30;
      t    = 64'd1 << (38 - FRAC_BITS);
      term = q30;
      e1   = q30;
      for (int n = 1; n <= 16; n++) begin
         term = udiv((term * t) >> 30, 64'(n));
         if ((n % 2) == 1) e1 = e1 - term;
         else e1 = e1 + term;
      end
      ek[0] = q30;
      for (int k = 1; k <= LUT_DEPTH; k++) begin
         ek[k] = (ek[k-1] * e1 + (64'd1 << 29)) >> 30;
      end
      for (int i = 0; i < LUT_DEPTH; i++) begin
         s = (i < LUT_DEPTH / 2) ? i : i - LUT_DEPTH;
         a = (s < 0) ? -s : s;
         if (!tanh_sel) begin
            den = q30 + ek[a];
            val = udiv((64'd1 << (FRAC_BITS + 30)) + (den >> 1), den);
            if (s < 0) val = (64'd1 << FRAC_BITS) - val;
         end else begin
            den = q30 + ek[2*a];
            val = udiv(((q30 - ek[2*a]) << FRAC_BITS) + (den >> 1), den);
            if (s < 0) val = -val;
         end
         res[i] = val[15:0];
      end
      return res;
   endfunction

   localparam lut_type SIG_LUT  = build_lut(1'b0);
   localparam lut_type TANH_LUT = build_lut(1'b1);

endpackage

FILE: rtl/rnn_ctrl.sv
module rnn_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_func,
   input  logic                     req_last,
   input  logic [5:0]               num_in,
   input  logic [5:0]               num_hid,
   input  logic [4:0]               num_out,
   input  rnn_pkg::dp_stat_type     stat,
   output logic                     req_tready,
   output rnn_pkg::dp_cmd_type      cmd
);
   import rnn_pkg::*;

   state_type        state_ff, state_in;
   logic [HID_W-1:0] j_ff, j_in;
   logic [HID_W-1:0] k_ff, k_in;
   logic             src_x_ff, src_x_in;
   logic             k_end_x, k_end_h, j_end_h, j_end_o;

   // End-of-loop flags for the row and column counters.
   assign k_end_x = ({1'b0, k_ff} == num_in - 6'd1);
   assign k_end_h = ({1'b0, k_ff} == num_hid - 6'd1);
   assign j_end_h = ({1'b0, j_ff} == num_hid - 6'd1);
   assign j_end_o = ({1'b0, j_ff} == {1'b0, num_out} - 6'd1);

   // State and counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         j_ff     <= '0;
         k_ff     <= '0;
         src_x_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         src_x_ff <= src_x_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      src_x_in     = src_x_ff;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.row      = j_ff;
      cmd.col      = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.req_fire = req_tvalid;
            if (req_tvalid && req_func && req_last) begin
               state_in = ST_HID_MAC;
               j_in     = '0;
               k_in     = '0;
               src_x_in = 1'b1;
            end
         end
         ST_HID_MAC: begin
            // One product per cycle: the x part of the row, then the recurrent part.
            cmd.mac_en = 1'b1;
            cmd.src_x  = src_x_ff;
            cmd.first  = src_x_ff && (k_ff == '0);
            cmd.last   = !src_x_ff && k_end_h;
            if (src_x_ff) begin
               if (k_end_x) begin
                  k_in     = '0;
                  src_x_in = 1'b0;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end else if (k_end_h) begin
               k_in     = '0;
               src_x_in = 1'b1;
               j_in     = j_ff + 1'b1;
               if (j_end_h) begin
                  state_in = ST_HID_DRAIN;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_HID_DRAIN: begin
            j_in = '0;
            k_in = '0;
            if (!stat.busy) begin
               state_in = ST_OUT_WAIT;
            end
         end
         ST_OUT_WAIT: begin
            k_in = '0;
            if (!stat.busy && !stat.rsp_full) begin
               state_in = ST_OUT_MAC;
            end
         end
         ST_OUT_MAC: begin
            cmd.mac_en    = 1'b1;
            cmd.out_phase = 1'b1;
            cmd.first     = (k_ff == '0);
            cmd.last      = k_end_h;
            cmd.row_last  = j_end_o;
            if (k_end_h) begin
               k_in = '0;
               if (j_end_o) begin
                  state_in = ST_FINISH;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_OUT_WAIT;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (!stat.busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/rnn_dp.sv
module rnn_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  rnn_pkg::dp_cmd_type    cmd,
   input  logic [1:0]             act_hidden,
   input  logic [1:0]             act_output,
   input  logic                   req_func,
   input  logic [2:0]             req_matrix_sel,
   input  logic [4:0]             req_row,
   input  logic [4:0]             req_col,
   input  logic signed [15:0]     req_value,
   input  logic                   req_seq_start,
   input  logic                   req_last_elem,
   input  logic                   rsp_tready,
   output logic signed [15:0]     rsp_value,
   output logic [3:0]             rsp_index,
   output logic                   rsp_last,
   output logic                   rsp_tvalid,
   output rnn_pkg::dp_stat_type   stat
);
   import rnn_pkg::*;

   // Weight memories and small register stores.
   logic signed [15:0] w_in_mem  [MAX_HID*MAX_IN];
   logic signed [15:0] w_rec_mem [MAX_HID*MAX_HID];
   logic signed [15:0] w_out_mem [MAX_OUT*MAX_HID];
   logic signed [15:0] bias_hid_ff [MAX_HID];
   logic signed [15:0] bias_out_ff [MAX_OUT];
   logic signed [15:0] init_ff     [MAX_HID];
   logic signed [15:0] hidden_ff   [MAX_HID];
   logic signed [15:0] hprev_ff    [MAX_HID];
   logic signed [15:0] x_ff        [MAX_IN];

   logic               is_load, is_elem;

   // Stage 1: read data.
   logic signed [15:0] w_in_rd_ff, w_rec_rd_ff, w_out_rd_ff;
   logic signed [15:0] opnd_ff, bias1_ff;
   logic               v1_ff, first1_ff, last1_ff, out1_ff, srcx1_ff, rlast1_ff;
   logic [HID_W-1:0]   row1_ff;
   // Stage 2: product.
   logic signed [15:0] weight1;
   logic signed [31:0] prod_ff;
   logic signed [15:0] bias2_ff;
   logic               v2_ff, first2_ff, last2_ff, out2_ff, rlast2_ff;
   logic [HID_W-1:0]   row2_ff;
   // Stage 3: accumulator.
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic               done3_ff, out3_ff, rlast3_ff;
   logic [HID_W-1:0]   row3_ff;
   // Finish stage.
   logic signed [ACC_W-1:0] rnd;
   logic signed [ACC_W-FRAC_BITS-1:0] quo;
   logic signed [15:0] zval, fval;
   logic [1:0]         act_sel;
   // Result register.
   logic signed [15:0] rsp_value_ff;
   logic [3:0]         rsp_index_ff;
   logic               rsp_last_ff, rsp_valid_ff;

   assign is_load = cmd.req_fire && !req_func;
   assign is_elem = cmd.req_fire && req_func;

   // Weight memories: one write port for loads, one registered read port.
   always_ff @(posedge clock) begin
      if (is_load && (req_matrix_sel == SEL_WX) && (32'(req_row) < MAX_HID)
          && (32'(req_col) < MAX_IN)) begin
         w_in_mem[{req_row[HID_W-1:0], req_col[IN_W-1:0]}] <= req_value;
      end
      if (is_load && (req_matrix_sel == SEL_WH) && (32'(req_row) < MAX_HID)
          && (32'(req_col) < MAX_HID)) begin
         w_rec_mem[{req_row[HID_W-1:0], req_col[HID_W-1:0]}] <= req_value;
      end
      if (is_load && (req_matrix_sel == SEL_WY) && (32'(req_row) < MAX_OUT)
          && (32'(req_col) < MAX_HID)) begin
         w_out_mem[{req_row[OUT_W-1:0], req_col[HID_W-1:0]}] <= req_value;
      end
      if (cmd.mac_en) begin
         w_in_rd_ff  <= w_in_mem[{cmd.row, cmd.col[IN_W-1:0]}];
         w_rec_rd_ff <= w_rec_mem[{cmd.row, cmd.col}];
         w_out_rd_ff <= w_out_mem[{cmd.row[OUT_W-1:0], cmd.col}];
      end
   end

   // Bias, initial state and input vector stores, and the snapshot of the
   // previous hidden state taken when a step starts.
   always_ff @(posedge clock) begin
      if (is_load && (req_matrix_sel == SEL_BH) && (32'(req_row) < MAX_HID)) begin
         bias_hid_ff[req_row[HID_W-1:0]] <= req_value;
      end
      if (is_load && (req_matrix_sel == SEL_BY) && (32'(req_row) < MAX_OUT)) begin
         bias_out_ff[req_row[OUT_W-1:0]] <= req_value;
      end
      if (is_load && (req_matrix_sel == SEL_H0) && (32'(req_row) < MAX_HID)) begin
         init_ff[req_row[HID_W-1:0]] <= req_value;
      end
      if (is_elem && (32'(req_col) < MAX_IN)) begin
         x_ff[req_col[IN_W-1:0]] <= req_value;
      end
      if (is_elem && req_last_elem) begin
         hprev_ff <= req_seq_start ? init_ff : hidden_ff;
      end
   end

   // Stage 1: operand and bias selection.
   always_ff @(posedge clock) begin
      if (cmd.out_phase) begin
         opnd_ff  <= hidden_ff[cmd.col];
         bias1_ff <= bias_out_ff[cmd.row[OUT_W-1:0]];
      end else begin
         opnd_ff  <= cmd.src_x ? x_ff[cmd.col[IN_W-1:0]] : hprev_ff[cmd.col];
         bias1_ff <= bias_hid_ff[cmd.row];
      end
      first1_ff <= cmd.first;
      last1_ff  <= cmd.last;
      out1_ff   <= cmd.out_phase;
      srcx1_ff  <= cmd.src_x;
      rlast1_ff <= cmd.row_last;
      row1_ff   <= cmd.row;
   end

   // Stage 2: one multiplication.
   assign weight1 = out1_ff ? w_out_rd_ff : (srcx1_ff ? w_in_rd_ff : w_rec_rd_ff);

   always_ff @(posedge clock) begin
      prod_ff   <= weight1 * opnd_ff;
      bias2_ff  <= bias1_ff;
      first2_ff <= first1_ff;
      last2_ff  <= last1_ff;
      out2_ff   <= out1_ff;
      rlast2_ff <= rlast1_ff;
      row2_ff   <= row1_ff;
   end

   // Stage 3: accumulation, seeded with the scaled bias on a row's first product.
   always_comb begin
      if (first2_ff) begin
         acc_in = {{(ACC_W-16-FRAC_BITS){bias2_ff[15]}}, bias2_ff, {FRAC_BITS{1'b0}}}
                  + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (v2_ff) begin
         acc_ff <= acc_in;
      end
      out3_ff   <= out2_ff;
      rlast3_ff <= rlast2_ff;
      row3_ff   <= row2_ff;
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         done3_ff <= 1'b0;
      end else begin
         v1_ff    <= cmd.mac_en;
         v2_ff    <= v1_ff;
         done3_ff <= v2_ff && last2_ff;
      end
   end

   // Finish: round to nearest, floor shift, saturate and activate.
   assign rnd     = acc_ff + ACC_W'(1 << (FRAC_BITS - 1));
   assign quo     = rnd[ACC_W-1:FRAC_BITS];
   assign act_sel = out3_ff ? act_output : act_hidden;

   always_comb begin
      if (quo > (ACC_W-FRAC_BITS)'(32767)) begin
         zval = 16'sh7FFF;
      end else if (quo < -(ACC_W-FRAC_BITS)'(32768)) begin
         zval = -16'sh8000;
      end else begin
         zval = quo[15:0];
      end
      case (act_sel)
         ACT_SIGMOID: fval = SIG_LUT[zval[15:8]];
         ACT_TANH:    fval = TANH_LUT[zval[15:8]];
         ACT_RELU:    fval = zval[15] ? 16'sd0 : zval;
         default:     fval = zval;
      endcase
   end

   // Hidden state, cleared by reset and written row by row.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_HID; i++) begin
            hidden_ff[i] <= '0;
         end
      end else if (done3_ff && !out3_ff) begin
         hidden_ff[row3_ff] <= fval;
      end
   end

   // Result register: filled by a finished output row, emptied by a transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done3_ff && out3_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (done3_ff && out3_ff) begin
         rsp_value_ff <= fval;
         rsp_index_ff <= 4'(row3_ff);
         rsp_last_ff  <= rlast3_ff;
      end
   end

   assign rsp_value     = rsp_value_ff;
   assign rsp_index     = rsp_index_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_tvalid    = rsp_valid_ff;
   assign stat.busy     = v1_ff || v2_ff || done3_ff;
   assign stat.rsp_full = rsp_valid_ff;

endmodule

FILE: rtl/rnn_cell_forward.sv
// Channel | Direction | Contents
// req     | in        | tdata: row, col, value; tuser: func, matrix_sel, seq_start;
//         |           | tlast: last_elem
// rsp     | out       | tdata: out_value, out_index; tlast: out_last
// csr     | in        | APB registers act_hidden, act_output, in_len, hid_len, out_len
//
// A parameter word or a non-final input element is only stored. The final
// element runs a step on one shared multiply-accumulate unit: hid_len * (in_len +
// hid_len) products for the hidden layer, a drain of the pipeline, then hid_len
// products per output element.
// Reset is synchronous and clears the control state and the hidden state.
// A stalled result holds the next output row back; no new item is taken until
// the step has run.
module rnn_cell_forward (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // row[4:0], col[9:5], value[25:10], zero fill
   input  logic [4:0]  req_tuser,   // func[0], matrix_sel[3:1], seq_start[4]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_value[15:0], out_index[19:16], zero fill
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rnn_pkg::*;

   logic [1:0]         act_hidden_ff, act_output_ff;
   logic [5:0]         in_len_ff, hid_len_ff;
   logic [4:0]         out_len_ff;
   logic [5:0]         num_in, num_hid;
   logic [4:0]         num_out;
   logic               csr_wr;
   reg_idx_type        csr_idx;
   dp_cmd_type         cmd;
   dp_stat_type        stat;
   logic signed [15:0] rsp_value;
   logic [3:0]         rsp_index;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = reg_idx_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         act_hidden_ff <= ACT_LINEAR;
         act_output_ff <= ACT_LINEAR;
         in_len_ff     <= 6'(MAX_IN);
         hid_len_ff    <= 6'(MAX_HID);
         out_len_ff    <= 5'(MAX_OUT);
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ACT_HIDDEN: act_hidden_ff <= csr_pwdata[1:0];
            REG_ACT_OUTPUT: act_output_ff <= csr_pwdata[1:0];
            REG_IN_LEN:     in_len_ff     <= csr_pwdata[5:0];
            REG_HID_LEN:    hid_len_ff    <= csr_pwdata[5:0];
            REG_OUT_LEN:    out_len_ff    <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (csr_idx)
         REG_ACT_HIDDEN: csr_prdata = {30'd0, act_hidden_ff};
         REG_ACT_OUTPUT: csr_prdata = {30'd0, act_output_ff};
         REG_IN_LEN:     csr_prdata = {26'd0, in_len_ff};
         REG_HID_LEN:    csr_prdata = {26'd0, hid_len_ff};
         REG_OUT_LEN:    csr_prdata = {27'd0, out_len_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // Lengths in use: zero acts as one, anything above the maximum as the maximum.
   assign num_in  = (in_len_ff == '0) ? 6'd1 :
                    ((32'(in_len_ff) > MAX_IN) ? 6'(MAX_IN) : in_len_ff);
   assign num_hid = (hid_len_ff == '0) ? 6'd1 :
                    ((32'(hid_len_ff) > MAX_HID) ? 6'(MAX_HID) : hid_len_ff);
   assign num_out = (out_len_ff == '0) ? 5'd1 :
                    ((32'(out_len_ff) > MAX_OUT) ? 5'(MAX_OUT) : out_len_ff);

   rnn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser[0]),
      .req_last   (req_tlast),
      .num_in     (num_in),
      .num_hid    (num_hid),
      .num_out    (num_out),
      .stat       (stat),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   rnn_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .act_hidden     (act_hidden_ff),
      .act_output     (act_output_ff),
      .req_func       (req_tuser[0]),
      .req_matrix_sel (req_tuser[3:1]),
      .req_row        (req_tdata[4:0]),
      .req_col        (req_tdata[9:5]),
      .req_value      (req_tdata[25:10]),
      .req_seq_start  (req_tuser[4]),
      .req_last_elem  (req_tlast),
      .rsp_tready     (rsp_tready),
      .rsp_value      (rsp_value),
      .rsp_index      (rsp_index),
      .rsp_last       (rsp_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .stat           (stat)
   );

   assign rsp_tdata = {4'd0, rsp_index, rsp_value};

endmodule
